FILE: sv/length_prefixed_frame_deframer_top_assert.svh
// Assertion macros for the length-prefixed frame deframer.
// Used by length_prefixed_frame_deframer_top; no other dependencies.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LPFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lpfd_pkg.sv
// Package for the length-prefixed frame deframer: beat types, parse phases
// and the reset sync value. No dependencies.
`default_nettype none

package lpfd_pkg;

  localparam logic [7:0] SYNC_RESET = 8'hAA;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_ID      = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
  } raw_beat_t;

  typedef struct packed {
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic        has_payload;
    logic        last_of_frame;
  } frame_beat_t;

endpackage

`default_nettype wire

FILE: sv/lpfd_stream_if.sv
// Valid/ready stream interface used for both deframer channels.
// Payload type is a parameter; the beat types come from lpfd_pkg.
`default_nettype none

interface lpfd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/length_prefixed_frame_deframer_top.sv
// Length-prefixed frame deframer: sync hunt, id, 16-bit LE length, payload.
// Depends on lpfd_pkg, lpfd_stream_if and the assertion macro header.
//
//  channel | dir | payload                                         | beat
//  raw     | in  | in_byte                                         | one link byte
//  frame   | out | frame_id, frame_length, payload_byte,           | one payload byte
//          |     | has_payload, last_of_frame                      | or empty marker
//  cfg     | in  | cfg_wdata (sync_byte) on cfg_we                 | register write
//
// One byte per cycle sustained while the frame sink is ready: input register -> parse logic -> result register.
// A raw byte reaches frame valid through the input register and then the result register.
// Header bytes and dropped hunt bytes produce no frame beat, except the empty-frame marker on a zero length.
// A stalled frame beat freezes the parser; the input register can still take a byte if it is empty.
// rst is synchronous, active high; sync_byte returns to 0xAA.
`default_nettype none

module length_prefixed_frame_deframer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  lpfd_stream_if.sink     raw,
  lpfd_stream_if.source   frame
);

  logic [7:0]          sync_byte;
  logic                in_valid;
  logic [7:0]          in_byte;
  logic                out_valid;
  lpfd_pkg::frame_beat_t out_data;

  lpfd_pkg::phase_t    phase, phase_next;
  logic [7:0]          held_id, held_id_next;
  logic [15:0]         held_length, held_length_next;
  logic [15:0]         bytes_remaining, bytes_remaining_next;

  logic                  result_valid;
  lpfd_pkg::frame_beat_t result;
  logic                  advance;

  // result register can take a new beat
  assign advance     = !out_valid || frame.ready;
  assign raw.ready   = !in_valid || advance;
  assign frame.valid = out_valid;
  assign frame.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= lpfd_pkg::SYNC_RESET;
    end else if (cfg_we) begin
      sync_byte <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (raw.ready) begin
      in_valid <= raw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw.ready) begin
      in_byte <= raw.data.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lpfd_pkg::PH_HUNT;
      held_id         <= '0;
      held_length     <= '0;
      bytes_remaining <= '0;
      out_valid       <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && result_valid;
      if (in_valid) begin
        phase           <= phase_next;
        held_id         <= held_id_next;
        held_length     <= held_length_next;
        bytes_remaining <= bytes_remaining_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && result_valid) begin
      out_data <= result;
    end
  end

  // next state
  always_comb begin
    phase_next           = phase;
    held_id_next         = held_id;
    held_length_next     = held_length;
    bytes_remaining_next = bytes_remaining;
    unique case (phase)
      lpfd_pkg::PH_ID: begin
        held_id_next = in_byte;
        phase_next   = lpfd_pkg::PH_LEN_LO;
      end
      lpfd_pkg::PH_LEN_LO: begin
        held_length_next = {8'h00, in_byte};
        phase_next       = lpfd_pkg::PH_LEN_HI;
      end
      lpfd_pkg::PH_LEN_HI: begin
        held_length_next     = {in_byte, held_length[7:0]};
        bytes_remaining_next = {in_byte, held_length[7:0]};
        if ({in_byte, held_length[7:0]} == 16'd0) begin
          phase_next = lpfd_pkg::PH_HUNT;
        end else begin
          phase_next = lpfd_pkg::PH_PAYLOAD;
        end
      end
      lpfd_pkg::PH_PAYLOAD: begin
        bytes_remaining_next = bytes_remaining - 16'd1;
        if (bytes_remaining == 16'd1) begin
          phase_next = lpfd_pkg::PH_HUNT;
        end
      end
      default: begin
        // hunting; unused codes fall back here
        if (in_byte == sync_byte) begin
          phase_next = lpfd_pkg::PH_ID;
        end else begin
          phase_next = lpfd_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // result beat
  always_comb begin
    result_valid         = 1'b0;
    result.frame_id      = held_id;
    result.frame_length  = held_length;
    result.payload_byte  = 8'h00;
    result.has_payload   = 1'b0;
    result.last_of_frame = 1'b0;
    unique case (phase)
      lpfd_pkg::PH_LEN_HI: begin
        // empty frame marker
        result_valid         = ({in_byte, held_length[7:0]} == 16'd0);
        result.frame_length  = 16'd0;
        result.last_of_frame = 1'b1;
      end
      lpfd_pkg::PH_PAYLOAD: begin
        result_valid         = 1'b1;
        result.payload_byte  = in_byte;
        result.has_payload   = 1'b1;
        result.last_of_frame = (bytes_remaining == 16'd1);
      end
      default: begin
        result_valid = 1'b0;
      end
    endcase
  end

`include "length_prefixed_frame_deframer_top_assert.svh"

  `LPFD_ASSERT_NOW(a_empty_marker_shape, clk, rst,
    out_valid && !out_data.has_payload,
    out_data.last_of_frame && out_data.payload_byte == 8'h00 && out_data.frame_length == 16'd0,
    "empty-frame marker with payload fields set")

  `LPFD_ASSERT_NOW(a_payload_count_nonzero, clk, rst,
    phase == lpfd_pkg::PH_PAYLOAD,
    bytes_remaining != 16'd0,
    "payload phase with no bytes remaining")

  `LPFD_ASSERT_NEXT(a_parser_frozen_on_stall, clk, rst,
    out_valid && !frame.ready,
    $stable(phase) && $stable(bytes_remaining),
    "parser moved while result beat stalled")

  `LPFD_ASSERT_NEXT(a_input_held_on_stall, clk, rst,
    in_valid && !advance,
    in_valid && $stable(in_byte),
    "input register lost a byte while blocked")

endmodule

`default_nettype wire

FILE: verif/length_prefixed_frame_deframer_top_tb.sv
// Testbench for length_prefixed_frame_deframer_top: random link bytes with framed traffic,
// an in-bench parser model predicting frame beats, and a scoreboard on the frame channel.
// Depends on lpfd_pkg, lpfd_stream_if and the deframer RTL.

module length_prefixed_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 150;
  localparam int HOLD_AT_BEAT = 500;
  localparam int PRINT_CAP    = 30;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  lpfd_stream_if #(.payload_t(lpfd_pkg::raw_beat_t))   raw_ch ();
  lpfd_stream_if #(.payload_t(lpfd_pkg::frame_beat_t)) frame_ch ();

  length_prefixed_frame_deframer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .raw       (raw_ch),
    .frame     (frame_ch)
  );

  always #1 clk = ~clk;

  // parser model state
  logic [7:0]        sync_val    = lpfd_pkg::SYNC_RESET;
  lpfd_pkg::phase_t  parse_phase = lpfd_pkg::PH_HUNT;
  logic [7:0]        held_id     = '0;
  logic [15:0]       held_len    = '0;
  logic [15:0]       left_bytes  = '0;

  lpfd_pkg::frame_beat_t pending_frame_beats[$];
  logic [7:0]  link_bytes[$];
  logic [7:0]  stim_sync = lpfd_pkg::SYNC_RESET;

  int  mismatches    = 0;
  int  raw_accepted  = 0;
  int  quiet_cycles  = 0;
  int  raw_gap       = 0;
  int  sink_stall    = 0;
  bit  steady        = 1'b0;
  bit  long_hold_done = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: frame beat mismatch on %s: got 0x%0h, expected 0x%0h",
               $time, what, got, want);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // one accepted link byte through the parser model
  task automatic advance_parser(input logic [7:0] b);
    lpfd_pkg::frame_beat_t beat;
    case (parse_phase)
      lpfd_pkg::PH_ID: begin
        held_id     = b;
        parse_phase = lpfd_pkg::PH_LEN_LO;
      end
      lpfd_pkg::PH_LEN_LO: begin
        held_len    = {8'h00, b};
        parse_phase = lpfd_pkg::PH_LEN_HI;
      end
      lpfd_pkg::PH_LEN_HI: begin
        held_len[15:8] = b;
        if (held_len == 16'h0000) begin
          beat = '{frame_id: held_id, frame_length: 16'h0000, payload_byte: 8'h00,
                   has_payload: 1'b0, last_of_frame: 1'b1};
          pending_frame_beats.push_back(beat);
          parse_phase = lpfd_pkg::PH_HUNT;
        end else begin
          left_bytes  = held_len;
          parse_phase = lpfd_pkg::PH_PAYLOAD;
        end
      end
      lpfd_pkg::PH_PAYLOAD: begin
        left_bytes = left_bytes - 16'd1;
        beat = '{frame_id: held_id, frame_length: held_len, payload_byte: b,
                 has_payload: 1'b1, last_of_frame: (left_bytes == 16'h0000)};
        pending_frame_beats.push_back(beat);
        if (left_bytes == 16'h0000) parse_phase = lpfd_pkg::PH_HUNT;
      end
      default: begin
        parse_phase = (b == sync_val) ? lpfd_pkg::PH_ID : lpfd_pkg::PH_HUNT;
      end
    endcase
  endtask

  // link byte driver
  always @(posedge clk) begin
    if (rst) begin
      raw_ch.valid <= 1'b0;
      raw_gap = 0;
    end else begin
      if (raw_ch.valid && raw_ch.ready) begin
        advance_parser(raw_ch.data.in_byte);
        raw_accepted++;
      end
      if (!raw_ch.valid || raw_ch.ready) begin
        if (raw_gap != 0) begin
          raw_gap--;
          raw_ch.valid <= 1'b0;
        end else if (link_bytes.size() != 0) begin
          raw_ch.valid        <= 1'b1;
          raw_ch.data.in_byte <= link_bytes.pop_front();
          raw_gap = pick_gap();
        end else begin
          raw_ch.valid <= 1'b0;
        end
      end
    end
  end

  // frame sink backpressure, with one long hold-off while the source keeps offering
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (!long_hold_done && raw_accepted >= HOLD_AT_BEAT) begin
        sink_stall     = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (sink_stall != 0) begin
        sink_stall--;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= 1'b1;
        sink_stall = pick_gap();
      end
    end
  end

  // frame beat monitor
  always @(posedge clk) begin
    lpfd_pkg::frame_beat_t want;
    lpfd_pkg::frame_beat_t got;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      got = frame_ch.data;
      if (pending_frame_beats.size() == 0) begin
        report_mismatch("unexpected beat, id", got.frame_id, 0);
      end else begin
        want = pending_frame_beats.pop_front();
        if (got.frame_id != want.frame_id)
          report_mismatch("frame_id", got.frame_id, want.frame_id);
        if (got.frame_length != want.frame_length)
          report_mismatch("frame_length", got.frame_length, want.frame_length);
        if (got.payload_byte != want.payload_byte)
          report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
        if (got.has_payload != want.has_payload)
          report_mismatch("has_payload", got.has_payload, want.has_payload);
        if (got.last_of_frame != want.last_of_frame)
          report_mismatch("last_of_frame", got.last_of_frame, want.last_of_frame);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst) begin
      if ((raw_ch.valid && raw_ch.ready) || (frame_ch.valid && frame_ch.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic queue_frame(input logic [7:0] id, input int len);
    link_bytes.push_back(stim_sync);
    link_bytes.push_back(id);
    link_bytes.push_back(len[7:0]);
    link_bytes.push_back(len[15:8]);
    repeat (len) link_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // hunt-phase junk; never the current sync value
  task automatic queue_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == stim_sync) b = ~b;
      link_bytes.push_back(b);
    end
  endtask

  task automatic queue_random_traffic(input int beats);
    int queued;
    int r;
    int len;
    queued = 0;
    while (queued < beats) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        queue_noise($urandom_range(1, 4));
      end else if (r < 18) begin
        queue_frame(8'($urandom_range(0, 255)), 0);
        queued += 4;
      end else begin
        len = $urandom_range(1, 24);
        queue_frame(8'($urandom_range(0, 255)), len);
        queued += len + 4;
      end
    end
  endtask

  // wait until every byte is taken and every beat is back
  task automatic drain_parser();
    do @(negedge clk);
    while (link_bytes.size() != 0 || raw_ch.valid || pending_frame_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sync_val  = v;
    stim_sync = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    raw_ch.valid   = 1'b0;
    raw_ch.data    = '0;
    frame_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, empty frame, sync value used as data
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    queue_frame(8'h00, 0);
    link_bytes.push_back(stim_sync);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'h01);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(stim_sync);
    link_bytes.push_back(stim_sync);
    link_bytes.push_back(stim_sync);
    link_bytes.push_back(8'h02);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'h00);
    // length with a nonzero high byte
    queue_frame(8'($urandom_range(0, 255)), $urandom_range(256, 280));
    queue_random_traffic(260);
    drain_parser();

    // sync change while a header is half taken: new value only counts at the next hunt
    link_bytes.push_back(stim_sync);
    link_bytes.push_back(8'h11);
    link_bytes.push_back(8'h03);
    drain_parser();
    write_sync(8'h00);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hAA);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'hAA);
    queue_random_traffic(260);
    drain_parser();

    // back-to-back phase with no idling
    write_sync(8'hFF);
    steady = 1'b1;
    queue_random_traffic(260);
    drain_parser();
    steady = 1'b0;

    write_sync(8'($urandom_range(1, 254)));
    queue_random_traffic(260);
    queue_noise(3);
    queue_frame(8'h00, 0);
    // largest declared length; only the head of its payload is sent
    link_bytes.push_back(stim_sync);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'hFF);
    repeat (8) link_bytes.push_back(8'($urandom_range(0, 255)));
    drain_parser();

    if (mismatches == 0 && pending_frame_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: length_prefixed_frame_deframer_top.f
+incdir+sv
sv/lpfd_pkg.sv
sv/lpfd_stream_if.sv
sv/length_prefixed_frame_deframer_top.sv
verif/length_prefixed_frame_deframer_top_tb.sv
